// ===== hw/rtl/preemptive_priority_scheduler_macros.svh =====
// Assertion macros used by the scheduler RTL.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset
`define PPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pps_pkg.sv =====
// Types and constants of the preemptive priority scheduler.
package pps_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int IDX_W   = 6;
    localparam int TIME_W  = 23;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_UPDATE,
        S_TURN,
        S_WAIT
    } t_state;

    // One stored process entry as read back from the stores
    typedef struct packed {
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] rem;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    // Outcome of one pass over the stored entries
    typedef struct packed {
        logic               have_pick;
        logic [IDX_W-1:0]   pick_idx;
        logic [PRIO_W-1:0]  pick_prio;
        logic [ARR_W-1:0]   pick_arr;
        logic [BURST_W-1:0] pick_rem;
        logic [BURST_W-1:0] pick_burst;
        logic               have_next;
        logic [ARR_W-1:0]   next_arr;
    } t_pick;

endpackage

// ===== hw/rtl/pps_scan.sv =====
// Selection unit: folds one valid entry per cycle into the best pick and the next arrival.
module pps_scan
    import pps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [IDX_W-1:0]  i_idx,
    input  t_entry            i_ent,
    input  logic [TIME_W-1:0] i_tick,
    output t_pick             o_res
);

    t_pick r_res;
    t_pick n_res;

    logic w_first;
    logic w_have_pick;
    logic w_have_next;
    logic w_arrived;

    // Compare the incoming entry against the running best
    always_comb begin
        w_first     = (i_idx == '0);
        w_have_pick = r_res.have_pick && !w_first;
        w_have_next = r_res.have_next && !w_first;
        w_arrived   = ({{(TIME_W-ARR_W){1'b0}}, i_ent.arr} <= i_tick);
        n_res           = r_res;
        n_res.have_pick = w_have_pick;
        n_res.have_next = w_have_next;
        if (i_ent.rem != '0) begin
            if (w_arrived) begin
                if (!w_have_pick || (i_ent.prio > r_res.pick_prio)) begin
                    n_res.have_pick  = 1'b1;
                    n_res.pick_idx   = i_idx;
                    n_res.pick_prio  = i_ent.prio;
                    n_res.pick_arr   = i_ent.arr;
                    n_res.pick_rem   = i_ent.rem;
                    n_res.pick_burst = i_ent.burst;
                end
            end else if (!w_have_next || (i_ent.arr < r_res.next_arr)) begin
                n_res.have_next = 1'b1;
                n_res.next_arr  = i_ent.arr;
            end
        end
    end

    // Hold the running best; flags clear at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.have_pick <= 1'b0;
            r_res.have_next <= 1'b0;
        end else if (i_vld) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// Loading takes beats back to back; input stalls from the last beat until the run ends.
// Each scheduling decision scans the held processes through the one selection unit, then
// S_DRAIN and S_DECIDE; S_UPDATE if one is ready, and S_TURN and S_WAIT if it finishes.
// One result beat per finished process; decisions per run are bounded by 2n.
// Output waits stall the run while the previous result beat is held.
// i_rst_n is synchronous, active low; it clears counts, time and valids, not the stores.
`include "preemptive_priority_scheduler_macros.svh"
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ARR_W-1:0]     i_arrival_time,
    input  logic [BURST_W-1:0]   i_burst_length,
    input  logic [PRIO_W-1:0]    i_priority_level,
    input  logic                 i_last_process,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [IDX_W-1:0]     o_process_index,
    output logic [TIME_W-1:0]    o_completion_time,
    output logic [TIME_W-1:0]    o_waiting_time,
    output logic [TIME_W-1:0]    o_turnaround_time,
    output logic                 o_last_result
);

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);

    // Process stores
    logic [ARR_W-1:0]   arrival_mem   [MAX_PROCESSES];
    logic [BURST_W-1:0] remaining_mem [MAX_PROCESSES];
    logic [BURST_W-1:0] burst_mem     [MAX_PROCESSES];
    logic [PRIO_W-1:0]  priority_mem  [MAX_PROCESSES];

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_loaded;
    logic [CW-1:0]       r_fin;
    logic [TIME_W-1:0]   r_tick;
    logic [IW-1:0]       r_scan_idx;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_cmp_idx;
    t_entry              r_ent_q;
    logic [BURST_W-1:0]  r_run;
    logic [TIME_W-1:0]   r_turn;
    logic                r_out_vld;
    logic [IDX_W-1:0]    r_out_idx;
    logic [TIME_W-1:0]   r_out_done;
    logic [TIME_W-1:0]   r_out_wait;
    logic [TIME_W-1:0]   r_out_turn;
    logic                r_out_last;

    t_pick               w_pick;
    logic                w_in_beat;
    logic                w_store;
    logic                w_issue;
    logic                w_scan_end;
    logic                w_load_out;
    logic                w_done_pick;
    logic                w_run_last;
    logic [TIME_W-1:0]   w_gap;
    logic                w_take_gap;
    logic [IW-1:0]       w_wr_addr;
    logic [BURST_W-1:0]  w_burst_in;
    logic [BURST_W-1:0]  w_rem_new;

    // Decode control from the state
    always_comb begin
        o_stall    = (r_state != S_LOAD);
        w_in_beat  = i_valid && (r_state == S_LOAD);
        w_store    = w_in_beat && (r_loaded < CW'(MAX_PROCESSES));
        w_issue    = (r_state == S_SCAN);
        w_scan_end = (CW'(r_scan_idx) == (r_loaded - CW'(1)));
        w_load_out = (r_state == S_WAIT) && (!r_out_vld || !i_stall);
        w_run_last = (r_fin == r_loaded);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_in_beat && i_last_process) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_scan_end) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = w_pick.have_pick ? S_UPDATE : S_SCAN;
            end
            S_UPDATE: begin
                n_state = w_done_pick ? S_TURN : S_SCAN;
            end
            S_TURN: n_state = S_WAIT;
            S_WAIT: begin
                if (w_load_out) n_state = w_run_last ? S_LOAD : S_SCAN;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Slice length and store update arithmetic
    always_comb begin
        w_gap       = TIME_W'(w_pick.next_arr) - r_tick;
        w_take_gap  = w_pick.have_next &&
                      (w_gap < {{(TIME_W-BURST_W){1'b0}}, w_pick.pick_rem});
        w_done_pick = (w_pick.pick_rem == r_run);
        w_rem_new   = w_pick.pick_rem - r_run;
        w_burst_in  = (i_burst_length == '0) ? BURST_W'(1) : i_burst_length;
        w_wr_addr   = (r_state == S_LOAD) ? r_loaded[IW-1:0] : w_pick.pick_idx[IW-1:0];
    end

    // Write and read the stores
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            arrival_mem[w_wr_addr]  <= i_arrival_time;
            burst_mem[w_wr_addr]    <= w_burst_in;
            priority_mem[w_wr_addr] <= i_priority_level;
        end
        if (w_store || (r_state == S_UPDATE)) begin
            remaining_mem[w_wr_addr] <= (r_state == S_LOAD) ? w_burst_in : w_rem_new;
        end
        r_ent_q.arr   <= arrival_mem[r_scan_idx];
        r_ent_q.rem   <= remaining_mem[r_scan_idx];
        r_ent_q.burst <= burst_mem[r_scan_idx];
        r_ent_q.prio  <= priority_mem[r_scan_idx];
        r_cmp_idx     <= r_scan_idx;
    end

    // Shared selection unit
    pps_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_cmp_vld),
        .i_idx   (IDX_W'(r_cmp_idx)),
        .i_ent   (r_ent_q),
        .i_tick  (r_tick),
        .o_res   (w_pick)
    );

    // Advance the sequencer and its counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_loaded   <= '0;
            r_fin      <= '0;
            r_tick     <= '0;
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_vld  <= w_issue;
            r_scan_idx <= w_issue ? (r_scan_idx + IW'(1)) : '0;
            if (w_store) r_loaded <= r_loaded + CW'(1);
            if (r_state == S_DECIDE && !w_pick.have_pick) begin
                r_tick <= TIME_W'(w_pick.next_arr);
            end
            if (r_state == S_UPDATE) r_tick <= r_tick + TIME_W'(r_run);
            if (r_state == S_TURN) r_fin <= r_fin + CW'(1);
            if (w_load_out && w_run_last) begin
                r_loaded <= '0;
                r_fin    <= '0;
                r_tick   <= '0;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Slice length, turnaround and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            r_run <= w_take_gap ? w_gap[BURST_W-1:0] : w_pick.pick_rem;
        end
        if (r_state == S_TURN) begin
            r_turn <= r_tick - TIME_W'(w_pick.pick_arr);
        end
        if (w_load_out) begin
            r_out_idx  <= w_pick.pick_idx;
            r_out_done <= r_tick;
            r_out_turn <= r_turn;
            r_out_wait <= r_turn - TIME_W'(w_pick.pick_burst);
            r_out_last <= w_run_last;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_process_index   = r_out_idx;
    assign o_completion_time = r_out_done;
    assign o_waiting_time    = r_out_wait;
    assign o_turnaround_time = r_out_turn;
    assign o_last_result     = r_out_last;

    `PPS_ASSERT_IMP(a_fin_below_loaded, r_state == S_SCAN, r_fin < r_loaded, "finished count reached load count mid-run")
    `PPS_ASSERT_IMP(a_decide_has_work, r_state == S_DECIDE, w_pick.have_pick || w_pick.have_next, "scan found neither ready process nor later arrival")
    `PPS_ASSERT_IMP(a_pick_unfinished, r_state == S_DECIDE && w_pick.have_pick, w_pick.pick_rem != '0, "picked a finished process")
    `PPS_ASSERT_NXT(a_slice_nonzero, r_state == S_DECIDE && w_pick.have_pick, r_run != '0, "zero-length run slice")

endmodule

// ===== verif/tb_preemptive_priority_scheduler.sv =====
// Self-checking testbench of the preemptive priority scheduler, with its own schedule predictor.
module tb_preemptive_priority_scheduler
    import pps_pkg::*;
();

    localparam int HELD_MAX       = 16;
    localparam int SETTLE_CYCLES  = 120;
    localparam int LONG_HOLD      = 400;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 18;

    // One completion beat: index, times and end-of-run flag
    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] done;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turn;
        logic              is_last;
    } t_completion;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_valid           = 1'b0;
    logic [ARR_W-1:0]    i_arrival_time    = '0;
    logic [BURST_W-1:0]  i_burst_length    = '0;
    logic [PRIO_W-1:0]   i_priority_level  = '0;
    logic                i_last_process    = 1'b0;
    logic                i_stall           = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [IDX_W-1:0]    o_process_index;
    logic [TIME_W-1:0]   o_completion_time;
    logic [TIME_W-1:0]   o_waiting_time;
    logic [TIME_W-1:0]   o_turnaround_time;
    logic                o_last_result;

    // Descriptors held for the coming run, as the block should hold them
    logic [ARR_W-1:0]    held_arrival [HELD_MAX];
    logic [BURST_W-1:0]  held_burst   [HELD_MAX];
    logic [BURST_W-1:0]  held_left    [HELD_MAX];
    logic [PRIO_W-1:0]   held_prio    [HELD_MAX];
    int                  held_count = 0;

    t_completion         expected_completions [$];
    int                  mismatch_count = 0;
    int                  idle_pct  = 0;
    int                  stall_pct = 0;
    logic                hold_on   = 1'b0;
    event                hold_go;

    preemptive_priority_scheduler #(
        .MAX_PROCESSES (HELD_MAX)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_arrival_time    (i_arrival_time),
        .i_burst_length    (i_burst_length),
        .i_priority_level  (i_priority_level),
        .i_last_process    (i_last_process),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_process_index   (o_process_index),
        .o_completion_time (o_completion_time),
        .o_waiting_time    (o_waiting_time),
        .o_turnaround_time (o_turnaround_time),
        .o_last_result     (o_last_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run the held batch decision by decision, jumping over idle stretches and preemption-free spans
    task automatic schedule_held_batch();
        int unsigned tick;
        int unsigned finished;
        int unsigned pick;
        int unsigned next_arr;
        int unsigned span;
        bit          have_pick;
        bit          have_next;
        t_completion c;
        tick     = 0;
        finished = 0;
        while (finished < held_count) begin
            have_pick = 1'b0;
            have_next = 1'b0;
            pick      = 0;
            next_arr  = 0;
            for (int i = 0; i < held_count; i++) begin
                if (held_left[i] == '0)
                    continue;
                if (held_arrival[i] <= tick) begin
                    // strict compare keeps the lowest index on a tie
                    if (!have_pick || held_prio[i] > held_prio[pick]) begin
                        have_pick = 1'b1;
                        pick      = i;
                    end
                end else if (!have_next || held_arrival[i] < next_arr) begin
                    have_next = 1'b1;
                    next_arr  = 32'(held_arrival[i]);
                end
            end
            if (!have_pick) begin
                tick = next_arr;
                continue;
            end
            span = 32'(held_left[pick]);
            if (have_next && next_arr - tick < span)
                span = next_arr - tick;
            tick            = tick + span;
            held_left[pick] = held_left[pick] - BURST_W'(span);
            if (held_left[pick] == '0) begin
                finished  = finished + 1;
                c.idx     = IDX_W'(pick);
                c.done    = TIME_W'(tick);
                c.turn    = TIME_W'(tick - 32'(held_arrival[pick]));
                c.waiting = TIME_W'(tick - 32'(held_arrival[pick]) - 32'(held_burst[pick]));
                c.is_last = (finished == held_count);
                expected_completions.push_back(c);
            end
        end
        held_count = 0;
    endtask

    // Store one accepted descriptor; a zero burst counts as one tick, a full store drops it
    task automatic record_descriptor(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                                     input logic [PRIO_W-1:0] prio, input logic lastp);
        logic [BURST_W-1:0] b;
        b = (burst == '0) ? BURST_W'(1) : burst;
        if (held_count < HELD_MAX) begin
            held_arrival[held_count] = arr;
            held_burst[held_count]   = b;
            held_left[held_count]    = b;
            held_prio[held_count]    = prio;
            held_count               = held_count + 1;
        end
        if (lastp)
            schedule_held_batch();
    endtask

    // Offer one descriptor beat after a random gap and hold it until accepted
    task automatic send_descriptor(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                                   input logic [PRIO_W-1:0] prio, input logic lastp);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_arrival_time   <= arr;
        i_burst_length   <= burst;
        i_priority_level <= prio;
        i_last_process   <= lastp;
        do
            @(posedge i_clk);
        while (o_stall);
        record_descriptor(arr, burst, prio, lastp);
    endtask

    // Drop valid, then wait for every expected completion and let the block settle
    task automatic wait_completions_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_completions.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [ARR_W-1:0] random_arrival();
        if ($urandom_range(3) == 0)
            return ARR_W'($urandom_range(0, 65535));
        return ARR_W'($urandom_range(0, 40));
    endfunction

    function automatic logic [BURST_W-1:0] random_burst();
        case ($urandom_range(5))
            0:       return BURST_W'($urandom_range(0, 65535));
            1:       return BURST_W'($urandom_range(0, 1));
            default: return BURST_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [PRIO_W-1:0] random_prio();
        if ($urandom_range(1) == 0)
            return PRIO_W'($urandom_range(0, 3));
        return PRIO_W'($urandom_range(0, 255));
    endfunction

    // Lone processes at the field extremes, and a zero burst
    task automatic test_single_extremes();
        send_descriptor(16'd0, 16'd1, 8'd0, 1'b1);
        send_descriptor(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_descriptor(16'd5, 16'd0, 8'd7, 1'b1);
        wait_completions_drained();
    endtask

    // Preemption by a later higher priority, a tie at equal priority, and an idle gap
    task automatic test_preemption_ties();
        send_descriptor(16'd0, 16'd10, 8'd1, 1'b0);
        send_descriptor(16'd2, 16'd3, 8'd5, 1'b0);
        send_descriptor(16'd2, 16'd2, 8'd5, 1'b0);
        send_descriptor(16'd30, 16'd4, 8'd0, 1'b1);
        wait_completions_drained();
    endtask

    // Fill the store, then offer two more; the last one is dropped but still starts the run
    task automatic test_store_full();
        for (int i = 0; i < HELD_MAX + 2; i++)
            send_descriptor(ARR_W'(i * 3), BURST_W'(i % 5 + 1), PRIO_W'(i % 4),
                            i == HELD_MAX + 1);
        wait_completions_drained();
    endtask

    // Random batches under each idling pattern; some batches overflow the store
    task automatic test_random_phases();
        int idle_plan  [4] = '{0, 77, 0, 15};
        int stall_plan [4] = '{0, 0, 77, 15};
        int made;
        int batch_len;
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  <= idle_plan[phase];
            stall_pct <= stall_plan[phase];
            made = 0;
            while (made < PHASE_ITEMS) begin
                if ($urandom_range(7) == 0)
                    batch_len = $urandom_range(HELD_MAX + 1, HELD_MAX + 4);
                else
                    batch_len = $urandom_range(1, HELD_MAX);
                for (int k = 0; k < batch_len; k++)
                    send_descriptor(random_arrival(), random_burst(), random_prio(),
                                    k == batch_len - 1);
                made = made + batch_len;
            end
            wait_completions_drained();
        end
        idle_pct  <= 0;
        stall_pct <= 0;
    endtask

    // Hold the output back for a long stretch while a second batch queues behind the first
    task automatic test_output_hold();
        -> hold_go;
        for (int k = 0; k < 5; k++)
            send_descriptor(random_arrival(), random_burst(), random_prio(), k == 4);
        for (int k = 0; k < 6; k++)
            send_descriptor(random_arrival(), random_burst(), random_prio(), k == 5);
        wait_completions_drained();
    endtask

    // Long receiver hold-off, counted here
    always begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Drive the receiver stall
    always @(posedge i_clk) begin
        i_stall <= hold_on || (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    // Check every accepted completion beat against the oldest expectation
    always @(posedge i_clk) begin : check_completions
        t_completion want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_completions.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected completion beat: idx %0d done %0d",
                             o_process_index, o_completion_time);
            end else begin
                want = expected_completions.pop_front();
                if (o_process_index !== want.idx || o_completion_time !== want.done ||
                    o_waiting_time !== want.waiting || o_turnaround_time !== want.turn ||
                    o_last_result !== want.is_last) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"completion mismatch (exp/got): idx %0d/%0d done %0d/%0d ",
                                  "wait %0d/%0d turn %0d/%0d last %0b/%0b"},
                                 want.idx, o_process_index, want.done, o_completion_time,
                                 want.waiting, o_waiting_time, want.turn, o_turnaround_time,
                                 want.is_last, o_last_result);
                end
            end
        end
    end

    // Bound the run
    initial begin
        #(2 * TIMEOUT_CYCLES);
        $display("preemptive_priority_scheduler test failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_extremes();
        test_preemption_ties();
        test_store_full();
        test_random_phases();
        test_output_hold();
        if (mismatch_count == 0)
            $display("preemptive_priority_scheduler test passed");
        else
            $display("preemptive_priority_scheduler test failed");
        $finish;
    end

endmodule
